// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/oets_pkg.sv
// shared types and constants for the odd-even transposition sorter
package oets_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 64;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic load;       // write the incoming item into the cell at the fill index
    logic sort;       // run one compare-exchange phase
    logic odd_phase;  // phase parity: 0 pairs (0,1),(2,3).. 1 pairs (1,2),(3,4)..
    logic shift;      // move every value one cell towards the output
  } cell_ctrl_t;

endpackage

// File: hdl/oets_cell.sv
// one storage cell of the sorting row with its compare-exchange logic
module oets_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                            clk,
  input  oets_pkg::cell_ctrl_t            ctrl,
  input  logic [CNT_W-1:0]                count,
  input  logic signed [oets_pkg::VALUE_W-1:0] in_val,
  input  logic signed [oets_pkg::VALUE_W-1:0] left_val,
  input  logic signed [oets_pkg::VALUE_W-1:0] right_val,
  input  logic                            left_gt,
  output logic signed [oets_pkg::VALUE_W-1:0] val,
  output logic                            gt
);

  localparam logic             IDX_ODD  = IDX[0];
  localparam logic [CNT_W-1:0] IDX_C    = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] IDX_P1_C = CNT_W'(IDX + 1);

  logic signed [oets_pkg::VALUE_W-1:0] val_next;
  logic is_left;
  logic left_active;
  logic right_active;

  // compare with the right neighbour, shared with it through gt
  assign gt = (val > right_val);

  // role in the current phase and whether the pair lies inside the set
  assign is_left      = (IDX_ODD == ctrl.odd_phase);
  assign left_active  = (IDX_P1_C < count);
  assign right_active = (IDX != 0) && (IDX_C < count);

  // next value of the cell
  always_comb begin
    val_next = val;
    if (ctrl.load) begin
      if (count == IDX_C) val_next = in_val;
    end else if (ctrl.sort) begin
      if (is_left) begin
        if (left_active && gt) val_next = right_val;
      end else begin
        if (right_active && left_gt) val_next = left_val;
      end
    end else if (ctrl.shift) begin
      val_next = right_val;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// File: hdl/odd_even_transposition_sorter_top.sv
// Operation: the items of a set are loaded, then n sort phases run (n = set size), then
// the n results go out at one per cycle while out_ready is high.
// The row of cells holds one set at a time: input is taken only while loading, and the
// next set is accepted in the cycle after the last result of the previous one is taken.
// Reset (rst, synchronous) empties the set and clears the overflow flag; cell contents
// are left as they are and only entries written in the current set are ever read.
module odd_even_transposition_sorter_top #(
  parameter int MAX_ITEMS = oets_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [oets_pkg::VALUE_W-1:0] value,
  input  logic                                last_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [oets_pkg::VALUE_W-1:0] sorted_value,
  output logic                                last_result,
  output logic                                overflowed
);

  localparam int               CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] phase;
  logic             ovf;

  oets_pkg::cell_ctrl_t ctrl;
  logic in_acc;
  logic out_acc;

  logic signed [oets_pkg::VALUE_W-1:0] vals [MAX_ITEMS];
  logic                                gts  [MAX_ITEMS];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // handshake and result outputs
  assign in_ready     = (state == ST_LOAD);
  assign out_valid    = (state == ST_EMIT);
  assign sorted_value = vals[0];
  assign last_result  = (count == ONE_C);
  assign overflowed   = ovf;

  // command to the cell row
  always_comb begin
    ctrl.load      = in_acc && (count < MAX_C);
    ctrl.sort      = (state == ST_SORT);
    ctrl.odd_phase = phase[0];
    ctrl.shift     = out_acc;
  end

  // control sequencer: load, sort phases, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      phase <= '0;
      ovf   <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (count < MAX_C) count <= count + ONE_C;
            else ovf <= 1'b1;
            if (last_item) begin
              state <= ST_SORT;
              phase <= '0;
            end
          end
        end
        ST_SORT: begin
          if (phase == count - ONE_C) state <= ST_EMIT;
          else phase <= phase + ONE_C;
        end
        ST_EMIT: begin
          if (out_acc) begin
            count <= count - ONE_C;
            if (count == ONE_C) begin
              state <= ST_LOAD;
              ovf   <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  // row of cells, each wired to its two neighbours
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [oets_pkg::VALUE_W-1:0] lv;
    logic signed [oets_pkg::VALUE_W-1:0] rv;
    logic                                lg;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid_l
      assign lv = vals[i-1];
      assign lg = gts[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign rv = '0;
    end else begin : g_mid_r
      assign rv = vals[i+1];
    end

    oets_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .in_val    (value),
      .left_val  (lv),
      .right_val (rv),
      .left_gt   (lg),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

endmodule

// File: hdl/oets_checker.sv
// port-level checks for the sorter, bound to the top level
`include "assert_macros.svh"

module oets_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        last_item,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sorted_value,
  input logic        last_result,
  input logic        overflowed
);

  // loading and emitting never overlap
  `ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "in_ready and out_valid both high")

  // the last item of a set closes the input side
  `ASSERT_NEXT(a_close_after_last, in_valid && in_ready && last_item, !in_ready, "input still open after last item")

  // the last result hands back to loading
  `ASSERT_NEXT(a_reopen_after_last, out_valid && out_ready && last_result, !out_valid && in_ready, "not back to loading after last result")

  // results of one set follow each other with the same overflow mark
  `ASSERT_NEXT(a_ovf_steady, out_valid && out_ready && !last_result, out_valid && $stable(overflowed), "overflow mark changed within a set")

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sorted_value) && $stable(last_result), "stalled result changed")

endmodule

bind odd_even_transposition_sorter_top oets_checker u_oets_checker (.*);

// File: tb/odd_even_transposition_sorter_top_tb.sv
// self-checking testbench for the odd-even transposition sorter top level
`timescale 1ns / 100ps

module odd_even_transposition_sorter_top_tb;

  localparam int W   = oets_pkg::VALUE_W;
  localparam int CAP = oets_pkg::MAX_ITEMS_DEF;

  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    bit                  drain_first;  // wait for every sorted result before offering
  } stim_item_t;

  typedef struct {
    logic signed [W-1:0] value;
    logic                last;
    logic                ovf;
  } sorted_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [W-1:0] value = '0;
  logic                last_item = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [W-1:0] sorted_value;
  logic                last_result;
  logic                overflowed;

  // items waiting to be offered and sorted results still due
  stim_item_t     pending_items[$];
  sorted_result_t sorted_expected[$];

  // predictor copy of the set being loaded
  logic signed [W-1:0] set_values [CAP];
  int                  set_count = 0;
  logic                set_overflow = 1'b0;

  int fail_count   = 0;
  int results_seen = 0;
  int send_gap     = 0;
  int hold_left    = 0;
  bit long_hold_done = 1'b0;
  bit quiet_tail   = 1'b0;

  odd_even_transposition_sorter_top #(.MAX_ITEMS(CAP)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflowed   (overflowed)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // store one accepted element; on the set's end sort and queue the results
  task automatic absorb_element(input logic signed [W-1:0] v, input logic last);
    sorted_result_t      r;
    logic signed [W-1:0] tmp;
    int                  n;
    begin
      if (set_count < CAP) begin
        set_values[set_count] = v;
        set_count++;
      end else begin
        set_overflow = 1'b1;
      end
      if (last) begin
        n = set_count;
        for (int phase = 0; phase < n; phase++) begin
          for (int i = phase % 2; i + 1 < n; i += 2) begin
            if (set_values[i] > set_values[i+1]) begin
              tmp             = set_values[i];
              set_values[i]   = set_values[i+1];
              set_values[i+1] = tmp;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          r.value = set_values[k];
          r.last  = (k == n - 1);
          r.ovf   = set_overflow;
          sorted_expected.push_back(r);
        end
        set_count    = 0;
        set_overflow = 1'b0;
      end
    end
  endtask

  task automatic push_item(input logic signed [W-1:0] v, input logic last, input bit drain);
    stim_item_t it;
    begin
      it.value       = v;
      it.last        = last;
      it.drain_first = drain;
      pending_items.push_back(it);
    end
  endtask

  // mix of full-range words, small values that repeat, and the extremes
  function automatic logic signed [W-1:0] random_element();
    int pick;
    begin
      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom;
      else if (pick < 8) return $signed($urandom_range(0, 8)) - 4;
      else if (pick == 8) return 32'sh7fffffff;
      else return 32'sh80000000;
    end
  endfunction

  task automatic queue_random_set(input int size, input bit drain);
    begin
      for (int i = 0; i < size; i++) begin
        push_item(random_element(), i == size - 1, drain && (i == 0));
      end
    end
  endtask

  // reset, stimulus and end of run
  initial begin
    int random_items;
    int sz;
    random_items = 0;

    // single-element sets at both extremes
    push_item(32'sh7fffffff, 1'b1, 1'b0);
    push_item(32'sh80000000, 1'b1, 1'b0);
    // pair that needs a swap
    push_item(5, 1'b0, 1'b0);
    push_item(-3, 1'b1, 1'b0);
    // equal values never swap
    push_item(7, 1'b0, 1'b1);
    push_item(7, 1'b0, 1'b0);
    push_item(7, 1'b1, 1'b0);
    // extremes and sign boundary
    push_item(32'sh7fffffff, 1'b0, 1'b0);
    push_item(32'sh80000000, 1'b0, 1'b0);
    push_item(0, 1'b0, 1'b0);
    push_item(-1, 1'b0, 1'b0);
    push_item(1, 1'b0, 1'b0);
    push_item(32'sh80000000, 1'b1, 1'b0);
    // already sorted, then reversed
    for (int i = 0; i < 4; i++) push_item(i, i == 3, 1'b0);
    for (int i = 3; i >= 0; i--) push_item(i, i == 0, 1'b0);

    // random sets, one of them past capacity so the marked item is dropped too
    for (int s = 0; s < 2 || random_items < 10; s++) begin
      if (s == 1) begin
        queue_random_set(CAP + 2, 1'b1);
      end else begin
        sz = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(1, 10);
        queue_random_set(sz, $urandom_range(0, 7) == 0);
        random_items += sz;
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (sorted_expected.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS odd_even_transposition_sorter_top");
    end else begin
      $display("FAIL odd_even_transposition_sorter_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL odd_even_transposition_sorter_top");
    $finish;
  end

  // input driver
  always @(posedge clk) begin : drive_items
    stim_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_element(value, last_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_items[0].drain_first && sorted_expected.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          in_valid  <= 1'b1;
          value     <= nxt.value;
          last_item <= nxt.last;
          if (!quiet_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
        end
      end
      quiet_tail <= (pending_items.size() < 25);
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk) begin : collect_results
    sorted_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (sorted_expected.size() == 0) begin
          $error("unexpected result: sorted_value %0d", sorted_value);
          fail_count++;
        end else begin
          want = sorted_expected.pop_front();
          if (sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, actual %0d", want.value, sorted_value);
            fail_count++;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0b, actual %0b", want.last, last_result);
            fail_count++;
          end
          if (overflowed !== want.ovf) begin
            $error("overflowed: expected %0b, actual %0b", want.ovf, overflowed);
            fail_count++;
          end
        end
      end

      // long hold-off once so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 20) begin
        long_hold_done = 1'b1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 6);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
